@@ src/skf_pkg.sv @@
// Shared types, widths and reset constants for the scalar Kalman filter.
// No dependencies; the filter, multiplier, divider and testbench files import it.
package skf_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int NUM_W     = PROD_W + 2;
    localparam int DIVD_W    = PROD_W + 1;
    localparam int DIVS_W    = DATA_W + 1;
    localparam int MUL_CNT_W = $clog2(DATA_W);
    localparam int DIV_CNT_W = $clog2(DIVD_W);
    localparam int ADDR_W    = 4;

    localparam logic [DATA_W-1:0] MEAS_VAR_RST = 32'd262144;
    localparam logic [DATA_W-1:0] MOT_VAR_RST  = 32'd131072;
    localparam logic [DATA_W-1:0] INIT_MEAN_RST = 32'd0;
    localparam logic [DATA_W-1:0] INIT_VAR_RST = 32'd655360000;
    localparam logic [DATA_W-1:0] SMAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SMIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] UMAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        REG_MEAS_VAR  = 2'd0,
        REG_MOT_VAR   = 2'd1,
        REG_INIT_MEAN = 2'd2,
        REG_INIT_VAR  = 2'd3
    } skf_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_LOAD,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } skf_state_t;

    typedef struct packed {
        logic s_ready;
        logic mul_start;
        logic div_start;
        logic out_load;
    } skf_ctrl_t;

    function automatic logic [DATA_W-1:0] at_least_one(input logic [DATA_W-1:0] v);
        return (v == '0) ? {{(DATA_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

@@ src/scalar_kalman_filter.sv @@
// Scalar Kalman filter top level: APB registers, sequencer, output register.
// Depends on skf_pkg, skf_mul and skf_div.
//
//  channel | ports               | payload (low bit up)
//  --------+---------------------+-----------------------------------------------
//  input   | s_tvalid/s_tready   | tdata: measurement, motion; tuser: first_of_run
//  result  | m_tvalid/m_tready   | tdata: upd mean, upd var, pred mean, pred var;
//          |                     | tuser: saturated
//  config  | APB psel/penable    | 4 x 32-bit registers at byte address 4*i
//
// Between one acceptance and the next, an item passes through 32 steps of the
// shift-add multipliers, 65 steps of the restoring dividers, and the sequencer
// states. One item is in flight at a time; s_tready is high only in the idle state.
// A finished item waits in the output register while the next one is accepted;
// the sequencer holds its final state while that register is still occupied.
// Synchronous active-low reset restores the register and estimate reset values.
module scalar_kalman_filter (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // [31:0] measurement, [63:32] motion
    input  logic         s_tuser,   // [0] first_of_run
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [31:0] updated_mean, [63:32] updated_variance,
                                    // [95:64] predicted_mean, [127:96] predicted_variance
    output logic         m_tuser,   // [0] saturated
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [skf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import skf_pkg::*;

    skf_state_t state_reg, state_next;
    skf_ctrl_t  ctrl;

    logic [DATA_W-1:0] meas_var_reg, mot_var_reg, init_mean_reg, init_var_reg;
    logic [DATA_W-1:0] est_mean_reg, est_var_reg;
    logic [1:0]        reg_sel;
    logic              cfg_wr;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meas_var_reg  <= MEAS_VAR_RST;
            mot_var_reg   <= MOT_VAR_RST;
            init_mean_reg <= INIT_MEAN_RST;
            init_var_reg  <= INIT_VAR_RST;
        end else if (cfg_wr) begin
            unique case (skf_reg_t'(reg_sel))
                REG_MEAS_VAR:  meas_var_reg  <= pwdata;
                REG_MOT_VAR:   mot_var_reg   <= pwdata;
                REG_INIT_MEAN: init_mean_reg <= pwdata;
                REG_INIT_VAR:  init_var_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (skf_reg_t'(reg_sel))
            REG_MEAS_VAR:  prdata = meas_var_reg;
            REG_MOT_VAR:   prdata = mot_var_reg;
            REG_INIT_MEAN: prdata = init_mean_reg;
            REG_INIT_VAR:  prdata = init_var_reg;
            default:       prdata = '0;
        endcase
    end

    // ---------------- operand selection at acceptance ----------------
    logic              in_accept;
    logic [DATA_W-1:0] m_sel, v_sel, z_in, r_eff;
    logic [DATA_W-1:0] m_mag, z_mag;

    assign in_accept = s_tvalid && s_tready;
    assign z_in      = s_tdata[31:0];
    assign m_sel     = s_tuser ? init_mean_reg : est_mean_reg;
    assign v_sel     = at_least_one(s_tuser ? init_var_reg : est_var_reg);
    assign r_eff     = at_least_one(meas_var_reg);
    assign m_mag     = m_sel[DATA_W-1] ? (~m_sel + 1'b1) : m_sel;
    assign z_mag     = z_in[DATA_W-1] ? (~z_in + 1'b1) : z_in;

    logic              sm_reg, sz_reg, neg_reg;
    logic [DATA_W-1:0] v_reg, mot_reg;

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            sm_reg  <= m_sel[DATA_W-1];
            sz_reg  <= z_in[DATA_W-1];
            v_reg   <= v_sel;
            mot_reg <= s_tdata[63:32];
        end
    end

    // ---------------- multipliers ----------------
    logic              mul_done_a, mul_done_b, mul_done_c, mul_done;
    logic [PROD_W-1:0] prod_mr, prod_zv, prod_vr;

    skf_mul u_mul_mr (
        .aclk(aclk), .aresetn(aresetn), .start(ctrl.mul_start),
        .a(m_mag), .b(r_eff), .done(mul_done_a), .product(prod_mr)
    );
    skf_mul u_mul_zv (
        .aclk(aclk), .aresetn(aresetn), .start(ctrl.mul_start),
        .a(z_mag), .b(v_sel), .done(mul_done_b), .product(prod_zv)
    );
    skf_mul u_mul_vr (
        .aclk(aclk), .aresetn(aresetn), .start(ctrl.mul_start),
        .a(v_sel), .b(r_eff), .done(mul_done_c), .product(prod_vr)
    );

    assign mul_done = mul_done_a && mul_done_b && mul_done_c;

    // ---------------- numerator sum and magnitude ----------------
    logic [NUM_W-1:0]  term_m, term_z, num_next, num_reg, num_mag;
    logic [DIVS_W-1:0] den;

    assign term_m   = sm_reg ? (~{2'b00, prod_mr} + 1'b1) : {2'b00, prod_mr};
    assign term_z   = sz_reg ? (~{2'b00, prod_zv} + 1'b1) : {2'b00, prod_zv};
    assign num_next = term_m + term_z;
    assign num_mag  = num_reg[NUM_W-1] ? (~num_reg + 1'b1) : num_reg;
    assign den      = {1'b0, v_reg} + {1'b0, r_eff};

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SUM) begin
            num_reg <= num_next;
        end
        if (ctrl.div_start) begin
            neg_reg <= num_reg[NUM_W-1];
        end
    end

    // ---------------- dividers ----------------
    logic              div_done_a, div_done_b, div_done;
    logic [DIVD_W-1:0] quot_mean, quot_var;

    skf_div u_div_mean (
        .aclk(aclk), .aresetn(aresetn), .start(ctrl.div_start),
        .dividend(num_mag[DIVD_W-1:0]), .divisor(den),
        .done(div_done_a), .quotient(quot_mean)
    );
    skf_div u_div_var (
        .aclk(aclk), .aresetn(aresetn), .start(ctrl.div_start),
        .dividend({1'b0, prod_vr}), .divisor(den),
        .done(div_done_b), .quotient(quot_var)
    );

    assign div_done = div_done_a && div_done_b;

    // ---------------- update results ----------------
    logic [DATA_W+1:0] um_ext, um_wide;
    logic [DATA_W-1:0] um_val, uv_raw, um_reg, uv_reg;
    logic              um_sat, uv_sat, sat_u_reg;

    assign um_ext  = {1'b0, quot_mean[DIVS_W-1:0]};
    assign um_wide = neg_reg ? (~um_ext + 1'b1) : um_ext;
    // clamp when the top three bits disagree
    assign um_sat  = !((um_wide[DATA_W+1:DATA_W-1] == 3'b000) ||
                       (um_wide[DATA_W+1:DATA_W-1] == 3'b111));
    assign um_val  = um_sat ? (um_wide[DATA_W+1] ? SMIN : SMAX) : um_wide[DATA_W-1:0];
    assign uv_raw  = quot_var[DATA_W-1:0];
    assign uv_sat  = (uv_raw == '0);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPD) begin
            um_reg    <= um_val;
            uv_reg    <= at_least_one(uv_raw);
            sat_u_reg <= um_sat || uv_sat;
        end
    end

    // ---------------- prediction ----------------
    logic [DATA_W:0]   pm_wide, pv_wide;
    logic [DATA_W-1:0] pm_val, pv_val;
    logic              pm_sat, pv_sat;

    assign pm_wide = {um_reg[DATA_W-1], um_reg} + {mot_reg[DATA_W-1], mot_reg};
    assign pm_sat  = pm_wide[DATA_W] != pm_wide[DATA_W-1];
    assign pm_val  = pm_sat ? (pm_wide[DATA_W] ? SMIN : SMAX) : pm_wide[DATA_W-1:0];
    assign pv_wide = {1'b0, uv_reg} + {1'b0, mot_var_reg};
    assign pv_sat  = pv_wide[DATA_W];
    assign pv_val  = pv_sat ? UMAX : pv_wide[DATA_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_mean_reg <= INIT_MEAN_RST;
            est_var_reg  <= INIT_VAR_RST;
        end else if (ctrl.out_load) begin
            est_mean_reg <= pm_val;
            est_var_reg  <= pv_val;
        end
    end

    // ---------------- output register ----------------
    logic         out_valid_reg;
    logic [127:0] out_data_reg;
    logic         out_user_reg;
    logic         out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            out_data_reg <= {pv_val, pm_val, uv_reg, um_reg};
            out_user_reg <= sat_u_reg || pm_sat || pv_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid)  state_next = ST_MUL;
            ST_MUL:  if (mul_done)  state_next = ST_SUM;
            ST_SUM:                 state_next = ST_LOAD;
            ST_LOAD:                state_next = ST_DIV;
            ST_DIV:  if (div_done)  state_next = ST_UPD;
            ST_UPD:                 state_next = ST_DONE;
            ST_DONE: if (out_free)  state_next = ST_IDLE;
            default:                state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl           = '0;
        ctrl.s_ready   = (state_reg == ST_IDLE);
        ctrl.mul_start = (state_reg == ST_IDLE) && s_tvalid;
        ctrl.div_start = (state_reg == ST_LOAD);
        ctrl.out_load  = (state_reg == ST_DONE) && out_free;
    end

    assign s_tready = ctrl.s_ready;

endmodule

@@ src/skf_mul.sv @@
// Radix-2 shift-add multiplier, unsigned 32 x 32, one multiplier bit per cycle.
// Depends on skf_pkg for widths.
module skf_mul (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [skf_pkg::DATA_W-1:0] a,
    input  logic [skf_pkg::DATA_W-1:0] b,
    output logic                       done,
    output logic [skf_pkg::PROD_W-1:0] product
);
    import skf_pkg::*;

    logic [DATA_W-1:0]    a_reg;
    logic [PROD_W-1:0]    p_reg, p_next;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DATA_W:0]      sum;

    // add the multiplicand into the high half when the shifted-out bit is set
    assign sum    = {1'b0, p_reg[PROD_W-1:DATA_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);
    assign p_next = {sum, p_reg[DATA_W-1:1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(DATA_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            p_reg <= {{DATA_W{1'b0}}, b};
        end else if (busy_reg) begin
            p_reg <= p_next;
        end
    end

    assign done    = done_reg;
    assign product = p_reg;

endmodule

@@ src/skf_div.sv @@
// Restoring divider, 65-bit dividend by 33-bit divisor, one quotient bit per cycle.
// Depends on skf_pkg for widths.
module skf_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [skf_pkg::DIVD_W-1:0] dividend,
    input  logic [skf_pkg::DIVS_W-1:0] divisor,
    output logic                       done,
    output logic [skf_pkg::DIVD_W-1:0] quotient
);
    import skf_pkg::*;

    logic [DIVD_W-1:0]    q_reg;
    logic [DIVS_W-1:0]    rem_reg, rem_next;
    logic [DIVS_W-1:0]    d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVS_W:0]      part;
    logic [DIVS_W+1:0]    diff;
    logic                 borrow;

    assign part     = {rem_reg, q_reg[DIVD_W-1]};
    assign diff     = {1'b0, part} - {2'b0, d_reg};
    assign borrow   = diff[DIVS_W+1];
    // keep the partial remainder when the trial subtract goes negative
    assign rem_next = borrow ? part[DIVS_W-1:0] : diff[DIVS_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[DIVD_W-2:0], ~borrow};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ src/skf_checker.sv @@
// Port-level checks for the scalar Kalman filter, bound to the top level.
// Depends on scalar_kalman_filter port names only.
module skf_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item in flight: no acceptance right after an acceptance
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // updated variance never drops below one LSB
    a_var_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:32] != 32'd0)
        else $error("updated variance is zero");

    // prediction never lowers the variance
    a_var_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[127:96] >= m_tdata[63:32])
        else $error("predicted variance below updated variance");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for scalar_kalman_filter: an in-bench Q16.16 Kalman predictor
// checks every result item; stimulus covers directed corners, random tracking runs and stalls.
// Depends on skf_pkg and the scalar_kalman_filter RTL.
module tb_top;
    import skf_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int SETTLE       = 8;
    localparam logic signed [71:0] S32_MAX = 72'sd2147483647;
    localparam logic signed [71:0] S32_MIN = -72'sd2147483648;
    localparam logic signed [71:0] U32_MAX = 72'sd4294967295;

    typedef struct {
        logic signed [31:0] upd_mean;
        logic [31:0]        upd_var;
        logic signed [31:0] pred_mean;
        logic [31:0]        pred_var;
        logic               saturated;
    } estimate_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata  = '0;     // [31:0] measurement, [63:32] motion
    logic                s_tuser  = 1'b0;   // [0] first_of_run
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [127:0]        m_tdata;           // upd mean, upd var, pred mean, pred var
    logic                m_tuser;           // [0] saturated
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predictor copy of the registers and the running estimate
    logic [31:0]        cfg_meas_var  = MEAS_VAR_RST;
    logic [31:0]        cfg_mot_var   = MOT_VAR_RST;
    logic signed [31:0] cfg_init_mean = INIT_MEAN_RST;
    logic [31:0]        cfg_init_var  = INIT_VAR_RST;
    logic signed [31:0] est_mean      = INIT_MEAN_RST;
    logic [31:0]        est_var       = INIT_VAR_RST;

    estimate_t expected_estimates[$];
    int        error_count     = 0;
    int        items_sent      = 0;
    int        results_checked = 0;
    int        settings_used   = 0;
    int        quiet_cycles    = 0;
    int        hold_request    = 0;
    bit        sender_stalls   = 1'b1;
    bit        receiver_stalls = 1'b1;

    scalar_kalman_filter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 aclk = ~aclk;

    function automatic logic [31:0] lsb_floor(input logic [31:0] x);
        return (x == 32'd0) ? 32'd1 : x;
    endfunction

    function automatic logic signed [31:0] clamp_s32(input logic signed [71:0] x,
                                                     inout logic hit);
        if (x > S32_MAX) begin
            hit = 1'b1;
            return SMAX;
        end
        if (x < S32_MIN) begin
            hit = 1'b1;
            return SMIN;
        end
        return x[31:0];
    endfunction

    // Measurement update then motion prediction; advances the held estimate.
    function automatic estimate_t kalman_step(input logic first, input logic signed [31:0] z,
                                              input logic signed [31:0] mot);
        estimate_t          res;
        logic               hit;
        logic signed [71:0] wm, wz, wr, wv, den, um, uv, pm, pv;
        hit = 1'b0;
        if (first) begin
            est_mean = cfg_init_mean;
            est_var  = lsb_floor(cfg_init_var);
        end
        wm  = est_mean;
        wz  = z;
        wr  = {40'd0, lsb_floor(cfg_meas_var)};
        wv  = {40'd0, lsb_floor(est_var)};
        den = wr + wv;
        um  = (wm * wr + wz * wv) / den;
        res.upd_mean = clamp_s32(um, hit);
        uv = (wv * wr) / den;
        if (uv == 0) begin
            uv  = 1;
            hit = 1'b1;
        end
        res.upd_var = uv[31:0];
        pm = res.upd_mean;
        pm = pm + mot;
        res.pred_mean = clamp_s32(pm, hit);
        pv = uv + {40'd0, cfg_mot_var};
        if (pv > U32_MAX) begin
            pv  = U32_MAX;
            hit = 1'b1;
        end
        res.pred_var  = pv[31:0];
        res.saturated = hit;
        est_mean = res.pred_mean;
        est_var  = res.pred_var;
        return res;
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(0, 5))
            0: return SMAX;
            1: return SMIN;
            2: return $urandom_range(0, 32'h0010_0000);
            3: return -$urandom_range(0, 32'h0010_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_variance();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return UMAX;
            3: return $urandom_range(1, 32'h0004_0000);
            4, 5: return $urandom_range(32'h0001_0000, 32'h1000_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            error_count++;
        end
    endfunction

    task automatic send_item(input logic first, input logic [31:0] z, input logic [31:0] mot);
        int gap;
        gap = sender_stalls ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 1)) begin
                // count only cycles in which the block could take the item
                while (gap > 0) begin
                    @(posedge aclk);
                    if (s_tready) gap--;
                end
                @(negedge aclk);
            end else begin
                repeat (gap) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mot, z};
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        expected_estimates.push_back(kalman_step(first, z, mot));
        items_sent++;
        @(negedge aclk);
    endtask

    // Measurement near the current estimate, mostly small motion.
    task automatic send_tracking_item(input logic first);
        logic [31:0] noise, z, mot, step_size;
        noise     = $urandom_range(0, 1 << $urandom_range(4, 24));
        z         = $urandom_range(0, 1) ? est_mean + noise : est_mean - noise;
        step_size = $urandom_range(0, 32'h0004_0000);
        if ($urandom_range(0, 15) == 0) mot = rand_q16();
        else mot = $urandom_range(0, 1) ? step_size : -step_size;
        send_item(first, z, mot);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_estimates.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input skf_reg_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_MEAS_VAR:  cfg_meas_var  = value;
            REG_MOT_VAR:   cfg_mot_var   = value;
            REG_INIT_MEAN: cfg_init_mean = value;
            REG_INIT_VAR:  cfg_init_var  = value;
        endcase
        @(negedge aclk);
        // the register reads back what was just written
        check_field("register readback", value, prdata);
    endtask

    task automatic configure(input logic [31:0] meas_var, input logic [31:0] mot_var,
                             input logic [31:0] init_mean, input logic [31:0] init_var);
        wait_idle();
        write_reg(REG_MEAS_VAR, meas_var);
        write_reg(REG_MOT_VAR, mot_var);
        write_reg(REG_INIT_MEAN, init_mean);
        write_reg(REG_INIT_VAR, init_var);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        settings_used++;
    endtask

    // No run started: the estimate comes from reset.
    task automatic test_reset_estimate();
        send_item(1'b0, 32'h0001_0000, 32'd0);
        send_item(1'b0, 32'hFFF0_0000, 32'h0000_8000);
        send_item(1'b0, SMAX, SMAX);
    endtask

    task automatic test_field_extremes();
        send_item(1'b1, SMAX, SMAX);
        send_item(1'b1, SMIN, SMIN);
        send_item(1'b1, 32'd0, 32'd0);
        send_item(1'b1, SMIN, SMAX);
        send_item(1'b0, SMAX, SMIN);
        send_item(1'b0, 32'hFFFF_FFFF, 32'd1);
    endtask

    task automatic test_variance_corners();
        // zero registers read as one LSB: updated variance truncates to zero
        configure(32'd0, 32'd0, SMIN, 32'd0);
        send_item(1'b1, SMAX, SMIN);
        send_item(1'b0, SMIN, SMIN);
        send_item(1'b0, 32'd0, 32'd0);
        // predicted variance overflows
        configure(UMAX, UMAX, SMAX, UMAX);
        send_item(1'b1, SMAX, SMAX);
        send_item(1'b0, SMIN, 32'd1);
        send_item(1'b0, 32'd0, SMIN);
        configure(32'd1, 32'd0, 32'd0, UMAX);
        send_item(1'b1, SMIN, 32'h0001_0000);
        send_item(1'b0, 32'h1234_5678, 32'd0);
        configure(UMAX, 32'd0, SMIN, 32'd1);
        send_item(1'b1, SMAX, 32'd0);
        send_item(1'b0, SMAX, SMAX);
    endtask

    task automatic test_back_to_back();
        int k;
        configure(MEAS_VAR_RST, MOT_VAR_RST, 32'h0010_0000, INIT_VAR_RST);
        sender_stalls   = 1'b0;
        receiver_stalls = 1'b0;
        for (k = 0; k < 40; k++) send_tracking_item(k == 0);
        wait_idle();
        sender_stalls   = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    task automatic test_receiver_hold();
        int k;
        wait_idle();
        hold_request = LONG_HOLD;
        for (k = 0; k < 10; k++) send_tracking_item(k == 0);
        // hold the sender until every result is back
        wait_idle();
        for (k = 0; k < 10; k++) send_item(1'b0, rand_q16(), rand_q16());
    endtask

    task automatic test_random_settings(input int phases, input int per_phase);
        int p, left, run_len, k;
        for (p = 0; p < phases; p++) begin
            configure(rand_variance(), rand_variance(), rand_q16(), rand_variance());
            left = per_phase;
            while (left > 0) begin
                run_len = $urandom_range(1, 40);
                for (k = 0; k < run_len && left > 0; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        send_item($urandom_range(0, 1), $urandom, $urandom);
                    else
                        send_tracking_item(k == 0);
                    left--;
                end
            end
        end
    endtask

    // Result side: stall for a drawn number of valid cycles per item, or a long hold.
    initial begin : result_sink
        int gap_left, hold_left;
        gap_left  = $urandom_range(0, 15);
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) gap_left = receiver_stalls ? $urandom_range(0, 15) : 0;
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (gap_left > 0 && m_tvalid) begin
                gap_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        estimate_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_estimates.size() == 0) begin
                $display("%0t: result %h / %b with nothing expected", $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                want = expected_estimates.pop_front();
                check_field("updated_mean", want.upd_mean, m_tdata[31:0]);
                check_field("updated_variance", want.upd_var, m_tdata[63:32]);
                check_field("predicted_mean", want.pred_mean, m_tdata[95:64]);
                check_field("predicted_variance", want.pred_var, m_tdata[127:96]);
                check_field("saturated", {31'd0, want.saturated}, {31'd0, m_tuser});
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("[scalar_kalman_filter] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : test_sequence
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_reset_estimate();
        test_field_extremes();
        test_variance_corners();
        test_back_to_back();
        test_receiver_hold();
        test_random_settings(5, 250);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Checked %0d of %0d items under %0d register settings,",
                 results_checked, items_sent, settings_used);
        $display("including clamping corners, run restarts, random stalls and a long hold.");
        if (error_count == 0) begin
            $display("[scalar_kalman_filter] OK");
        end else begin
            $display("[scalar_kalman_filter] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/skf_pkg.sv
src/skf_mul.sv
src/skf_div.sv
src/scalar_kalman_filter.sv
src/skf_checker.sv
tb/tb_top.sv
